### hdl/bvps_pkg.sv
// ---------------------------------------------------------------------------
// Body velocity and position step: shared package
// Types, codes and constants used by the controller, the datapath and the
// top level of the body stepper.
// ---------------------------------------------------------------------------
`default_nettype none

package bvps_pkg;

  // Number of CORDIC micro-rotations used for the top-view drag direction.
  localparam int unsigned CordicIterations = 16;
  localparam int unsigned IterW            = $clog2(CordicIterations);

  // round(2^16 / CORDIC gain), pre-scales the drag vector.
  localparam logic [15:0] InvGainQ16 = 16'd39797;

  // Velocity limit, 100.0 in Q8.8.
  localparam int VelLimit = 25600;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgBodyFixed   = 3'd0,
    CfgGravityOn   = 3'd1,
    CfgTopView     = 3'd2,
    CfgDragStep    = 3'd3,
    CfgGravityStep = 3'd4
  } cfg_idx_e;

  // Item operation codes.
  typedef enum logic [1:0] {
    OpTick    = 2'd0,
    OpLoadVel = 2'd1,
    OpLoadPos = 2'd2
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle,
    StRotate,
    StVel,
    StPos
  } ctl_state_e;

  // One input item.
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] load_vel_x;
    logic signed [15:0] load_vel_y;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [15:0] vel_x_out;
    logic signed [15:0] vel_y_out;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;
    logic             rotate;
    logic [IterW-1:0] iter;
    logic             vel_update;
    logic             pos_update;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_rotate;
  } dp_status_t;

endpackage

`default_nettype wire

### hdl/bvps_ctrl.sv
// ---------------------------------------------------------------------------
// Body velocity and position step: controller
// Sequences one item at a time through capture, CORDIC micro-rotations when
// needed, velocity update and position update, and owns the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module bvps_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  input  bvps_pkg::dp_status_t status_i,
  output bvps_pkg::ctl_cmd_t   cmd_o
);
  import bvps_pkg::*;

  ctl_state_e       state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             out_valid_q, out_valid_d;
  logic             last_iter;

  assign last_iter = (iter_q == IterW'(CordicIterations - 1));

  // State, iteration counter and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d        = state_q;
    iter_d         = iter_q;
    out_valid_d    = out_valid_q & out_stall_i;
    cmd_o          = '0;
    cmd_o.iter     = iter_q;
    in_stall_o     = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          iter_d       = '0;
          state_d      = status_i.needs_rotate ? StRotate : StVel;
        end
      end
      StRotate: begin
        cmd_o.rotate = 1'b1;
        iter_d       = iter_q + IterW'(1);
        if (last_iter) begin
          state_d = StVel;
        end
      end
      StVel: begin
        cmd_o.vel_update = 1'b1;
        state_d          = StPos;
      end
      StPos: begin
        // The result register must be free or being emptied this cycle.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.pos_update = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // A result only appears after the position update.
  a_valid_from_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StPos))
    else $error("result valid raised outside the position update");

  // The rotation count starts from zero for every top-view tick of a free body.
  a_iter_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && in_valid_i && status_i.needs_rotate) |=>
      (state_q == StRotate && iter_q == '0))
    else $error("CORDIC did not start at iteration zero");

  // The last micro-rotation hands over to the velocity update.
  a_iter_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRotate && last_iter) |=> state_q == StVel)
    else $error("CORDIC overran its iteration count");

  // A waiting result is never overwritten.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPos && out_valid_q && out_stall_i) |=> state_q == StPos)
    else $error("new result written over a stalled one");
`endif

endmodule

`default_nettype wire

### hdl/bvps_datapath.sv
// ---------------------------------------------------------------------------
// Body velocity and position step: datapath
// Holds the configuration, the body state, the captured item, the CORDIC
// registers and the result register, and applies the controller's commands.
// ---------------------------------------------------------------------------
`default_nettype none

module bvps_datapath (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [2:0]           cfg_index_i,
  input  wire  [15:0]          cfg_wdata_i,
  input  bvps_pkg::in_item_t   in_data_i,
  output bvps_pkg::out_item_t  out_data_o,
  input  bvps_pkg::ctl_cmd_t   cmd_i,
  output bvps_pkg::dp_status_t status_o
);
  import bvps_pkg::*;

  // Subtract cut from v, stopping at zero if the result crosses it; zero stays zero.
  function automatic logic signed [19:0] stop_at_zero(logic signed [19:0] v,
                                                      logic signed [19:0] cut);
    logic signed [19:0] r;
    r = v - cut;
    if (v > 20'sd0) begin
      return (r < 20'sd0) ? 20'sd0 : r;
    end else if (v < 20'sd0) begin
      return (r > 20'sd0) ? 20'sd0 : r;
    end
    return v;
  endfunction

  // Saturate to plus or minus the velocity limit.
  function automatic logic signed [15:0] clamp_vel(logic signed [19:0] v);
    if (v >= 20'(VelLimit)) begin
      return 16'(VelLimit);
    end else if (v <= -20'(VelLimit)) begin
      return -16'(VelLimit);
    end
    return v[15:0];
  endfunction

  // Configuration registers.
  logic               body_fixed_q, gravity_on_q, top_view_q;
  logic [14:0]        drag_step_q;
  logic signed [15:0] gravity_step_q;

  // Body state.
  logic signed [15:0] vel_x_q, vel_y_q, vel_x_d, vel_y_d;
  logic signed [31:0] pos_x_q, pos_y_q, pos_x_d, pos_y_d;

  // Captured item and CORDIC working registers.
  in_item_t           item_q;
  logic               turned_q;
  logic signed [33:0] x_q, y_q, cx_q, cy_q;
  out_item_t          out_q;

  // CORDIC start values.
  logic               turned_init;
  logic signed [16:0] vx_init, vy_init;
  logic [30:0]        drag_prod;

  // Micro-rotation terms.
  logic signed [33:0] y_sh, x_sh, cx_sh, cy_sh;

  // Velocity update terms.
  logic signed [33:0] cx_rnd, cy_rnd;
  logic signed [19:0] share_x, share_y, vx_w, vy_w, vx_n, vy_n;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_fixed_q   <= 1'b0;
      gravity_on_q   <= 1'b1;
      top_view_q     <= 1'b0;
      drag_step_q    <= 15'd128;
      gravity_step_q <= 16'sd64;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBodyFixed:   body_fixed_q   <= cfg_wdata_i[0];
        CfgGravityOn:   gravity_on_q   <= cfg_wdata_i[0];
        CfgTopView:     top_view_q     <= cfg_wdata_i[0];
        CfgDragStep:    drag_step_q    <= cfg_wdata_i[14:0];
        CfgGravityStep: gravity_step_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Only a tick of a free body in top view needs the CORDIC.
  assign status_o.needs_rotate = (in_data_i.operation == OpTick) && !body_fixed_q && top_view_q;

  // Start values: the velocity is turned by half a turn when x is negative.
  assign turned_init = vel_x_q[15];
  assign vx_init     = turned_init ? -17'(vel_x_q) : 17'(vel_x_q);
  assign vy_init     = turned_init ? -17'(vel_y_q) : 17'(vel_y_q);
  assign drag_prod   = 31'(drag_step_q) * 31'(InvGainQ16);

  // Arithmetic shifts for the current micro-rotation.
  assign y_sh  = y_q >>> cmd_i.iter;
  assign x_sh  = x_q >>> cmd_i.iter;
  assign cx_sh = cx_q >>> cmd_i.iter;
  assign cy_sh = cy_q >>> cmd_i.iter;

  // Item capture and CORDIC iterations.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q   <= in_data_i;
      turned_q <= turned_init;
      x_q      <= {vx_init[16], vx_init, 16'h0000};
      y_q      <= {vy_init[16], vy_init, 16'h0000};
      cx_q     <= {3'b000, drag_prod};
      cy_q     <= '0;
    end else if (cmd_i.rotate) begin
      // The vector turns towards the x axis, the drag vector the other way.
      if (!y_q[33]) begin
        x_q  <= x_q + y_sh;
        y_q  <= y_q - x_sh;
        cx_q <= cx_q - cy_sh;
        cy_q <= cy_q + cx_sh;
      end else begin
        x_q  <= x_q - y_sh;
        y_q  <= y_q + x_sh;
        cx_q <= cx_q + cy_sh;
        cy_q <= cy_q - cx_sh;
      end
    end
  end

  // Drag shares, rounded to Q8.8 and turned back when needed.
  assign cx_rnd  = cx_q + 34'sd32768;
  assign cy_rnd  = cy_q + 34'sd32768;
  assign share_x = turned_q ? -20'($signed(cx_rnd[33:16])) : 20'($signed(cx_rnd[33:16]));
  assign share_y = turned_q ? -20'($signed(cy_rnd[33:16])) : 20'($signed(cy_rnd[33:16]));

  // Velocity update for a tick, then the clamp, or the loaded velocity.
  always_comb begin
    vx_w = 20'(vel_x_q);
    vy_w = 20'(vel_y_q);
    vx_n = vx_w;
    vy_n = vy_w;
    if (!body_fixed_q) begin
      if (!top_view_q) begin
        vy_n = gravity_on_q ? vy_w + 20'(gravity_step_q) : vy_w;
        vx_n = stop_at_zero(vx_w, 20'($signed({1'b0, drag_step_q})));
      end else begin
        vx_n = stop_at_zero(vx_w, share_x);
        vy_n = stop_at_zero(vy_w, share_y);
      end
    end
    vel_x_d = vel_x_q;
    vel_y_d = vel_y_q;
    case (item_q.operation)
      OpTick: begin
        vel_x_d = clamp_vel(vx_n);
        vel_y_d = clamp_vel(vy_n);
      end
      OpLoadVel: begin
        vel_x_d = item_q.load_vel_x;
        vel_y_d = item_q.load_vel_y;
      end
      default: ;
    endcase
  end

  // Position update: the sum wraps.
  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    case (item_q.operation)
      OpTick: begin
        pos_x_d = pos_x_q + 32'(vel_x_q);
        pos_y_d = pos_y_q + 32'(vel_y_q);
      end
      OpLoadPos: begin
        pos_x_d = item_q.load_pos_x;
        pos_y_d = item_q.load_pos_y;
      end
      default: ;
    endcase
  end

  // Body state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_x_q <= '0;
      vel_y_q <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else begin
      if (cmd_i.vel_update) begin
        vel_x_q <= vel_x_d;
        vel_y_q <= vel_y_d;
      end
      if (cmd_i.pos_update) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
      end
    end
  end

  // Result register, loaded together with the position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_update) begin
      out_q.pos_x_out <= pos_x_d;
      out_q.pos_y_out <= pos_y_d;
      out_q.vel_x_out <= vel_x_q;
      out_q.vel_y_out <= vel_y_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

### hdl/body_velocity_position_step.sv
// ---------------------------------------------------------------------------
// Body velocity and position step: top level
// Steps the velocity and position of one body per tick with gravity and
// drag, or loads velocity or position, and reports the state after each item.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_stall_o    in_data_i  (in_item_t)
//   out       output     out_valid_o / out_stall_i  out_data_o (out_item_t)
//   cfg       input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// An item passes from transfer through the velocity update and the position
// update into the result register; a top-view tick of a free body first runs
// the CordicIterations CORDIC micro-rotations. One item is worked on at a time.
// The next item is taken while a result still waits in the output register.
// Reset clears the body state to zero and the configuration registers to their defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module body_velocity_position_step (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [2:0]          cfg_index_i,
  input  wire  [15:0]         cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  bvps_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output bvps_pkg::out_item_t out_data_o
);
  import bvps_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Sequencer.
  bvps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  bvps_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire
